FILE: design/ast_pkg.sv
// Package for the accessory service set tracker.
// Holds operation codes, read state codes, the controller state type and the
// command and status structs that join the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

   localparam logic [2:0] FUNC_SERVICE  = 3'd0;
   localparam logic [2:0] FUNC_LINK     = 3'd1;
   localparam logic [2:0] FUNC_QUERY    = 3'd2;
   localparam logic [2:0] FUNC_CAS      = 3'd3;
   localparam logic [2:0] FUNC_SET      = 3'd4;
   localparam logic [2:0] FUNC_RESET    = 3'd5;

   localparam logic [2:0] RD_UNSUB      = 3'd0;
   localparam logic [2:0] RD_READY      = 3'd1;
   localparam logic [2:0] RD_NOTIFY     = 3'd2;
   localparam logic [2:0] RD_DISABLED   = 3'd3;
   localparam logic [2:0] RD_READING    = 3'd4;
   localparam logic [2:0] RD_COMPLETE   = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_EXEC,
      ST_DRAIN_RD,
      ST_DRAIN_EMIT
   } ast_state_type;

   typedef struct packed {
      logic load;
      logic idx_inc;
      logic idx_dec;
      logic idx_last;
      logic rd_en;
      logic rd_last;
      logic hit_set;
      logic move_wr;
      logic exec;
      logic drain_emit;
   } ast_cmd_type;

   typedef struct packed {
      logic scan_func;
      logic svc_remove;
      logic link_drop;
      logic scan_end;
      logic hit;
      logic idx_zero;
   } ast_sts_type;

   function automatic logic ast_legal(input logic [2:0] from, input logic [2:0] to);
      logic ok;
      ok = 1'b0;
      if (to == RD_UNSUB) begin
         ok = 1'b1;
      end else begin
         case (from)
            RD_UNSUB:    ok = (to == RD_READY);
            RD_READY:    ok = (to == RD_NOTIFY) || (to == RD_DISABLED);
            RD_NOTIFY:   ok = (to == RD_COMPLETE);
            RD_DISABLED: ok = (to == RD_READING) || (to == RD_READY);
            RD_READING:  ok = (to == RD_COMPLETE);
            RD_COMPLETE: ok = (to == RD_READY);
            default:     ok = 1'b0;
         endcase
      end
      return ok;
   endfunction

endpackage

`default_nettype wire

FILE: design/accessory_service_set_tracker.sv
// Top level of the accessory service set tracker.
// Instantiates ast_ctrl and ast_dp; depends on ast_pkg for the shared structs.
//
// Channel   Direction  Handshake              Ports
// request   in         start high, busy low   req_func .. req_next_state
// response  out        rsp_strobe, one cycle  rsp_event_valid .. rsp_last
//
// One request is in work at a time; busy stays high until its last response.
// A query or service update scans the table, reading and then comparing each
// table slot in the scan loop.
// A link drop reads and then emits each removed service; other requests go to execution.
// Each response leaves the output register in the cycle after it is formed.
// Reset is synchronous; the table needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module accessory_service_set_tracker #(
   parameter int MAX_SERVICES = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [2:0]  req_func,
   input  wire  [15:0] req_service_id,
   input  wire         req_connected,
   input  wire  [2:0]  req_expected_state,
   input  wire  [2:0]  req_next_state,
   output logic        rsp_strobe,
   output logic        rsp_event_valid,
   output logic [15:0] rsp_event_service_id,
   output logic        rsp_event_ok,
   output logic        rsp_answer,
   output logic        rsp_error,
   output logic [2:0]  rsp_fsm_now,
   output logic        rsp_link_usable,
   output logic        rsp_last
);
   import ast_pkg::*;

   ast_cmd_type cmd;
   ast_sts_type sts;

   ast_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   ast_dp #(
      .MAX_SERVICES (MAX_SERVICES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_func             (req_func),
      .req_service_id       (req_service_id),
      .req_connected        (req_connected),
      .req_expected_state   (req_expected_state),
      .req_next_state       (req_next_state),
      .rsp_strobe           (rsp_strobe),
      .rsp_event_valid      (rsp_event_valid),
      .rsp_event_service_id (rsp_event_service_id),
      .rsp_event_ok         (rsp_event_ok),
      .rsp_answer           (rsp_answer),
      .rsp_error            (rsp_error),
      .rsp_fsm_now          (rsp_fsm_now),
      .rsp_link_usable      (rsp_link_usable),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

FILE: design/ast_ctrl.sv
// Controller state machine of the accessory service set tracker.
// Depends on ast_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ast_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  ast_pkg::ast_sts_type  sts,
   output ast_pkg::ast_cmd_type  cmd
);
   import ast_pkg::*;

   ast_state_type state_ff;
   ast_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.scan_func) state_in = ST_SCAN_RD;
            else if (sts.link_drop) state_in = ST_DRAIN_RD;
            else state_in = ST_EXEC;
         end
         ST_SCAN_RD: begin
            if (sts.scan_end) state_in = ST_EXEC;
            else state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (sts.hit) state_in = sts.svc_remove ? ST_MOVE_RD : ST_EXEC;
            else state_in = ST_SCAN_RD;
         end
         ST_MOVE_RD:    state_in = ST_MOVE_WR;
         ST_MOVE_WR:    state_in = ST_EXEC;
         ST_EXEC:       state_in = ST_IDLE;
         ST_DRAIN_RD:   state_in = ST_DRAIN_EMIT;
         ST_DRAIN_EMIT: begin
            if (sts.idx_zero) state_in = ST_IDLE;
            else state_in = ST_DRAIN_RD;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_DECODE: begin
            cmd.idx_last = !sts.scan_func && sts.link_drop;
         end
         ST_SCAN_RD: begin
            cmd.rd_en = !sts.scan_end;
         end
         ST_SCAN_CMP: begin
            cmd.hit_set = sts.hit;
            cmd.idx_inc = !sts.hit;
         end
         ST_MOVE_RD:  cmd.rd_last = 1'b1;
         ST_MOVE_WR:  cmd.move_wr = 1'b1;
         ST_EXEC:     cmd.exec = 1'b1;
         ST_DRAIN_RD: cmd.rd_en = 1'b1;
         ST_DRAIN_EMIT: begin
            cmd.drain_emit = 1'b1;
            cmd.idx_dec    = !sts.idx_zero;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_DECODE))
      else $error("Accepted request did not enter decode.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> !busy)
      else $error("Controller stayed busy after the final result.");

   assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.exec, cmd.drain_emit, cmd.move_wr}) <= 1)
      else $error("Conflicting datapath commands.");

endmodule

`default_nettype wire

FILE: design/ast_dp.sv
// Datapath of the accessory service set tracker: service table memory,
// scan index, set count, link flag, read state and the result registers.
// Depends on ast_pkg for codes, the transition check and the command structs.
`timescale 1ns / 1ps
`default_nettype none

module ast_dp #(
   parameter int MAX_SERVICES = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  ast_pkg::ast_cmd_type  cmd,
   output ast_pkg::ast_sts_type  sts,
   input  wire  [2:0]            req_func,
   input  wire  [15:0]           req_service_id,
   input  wire                   req_connected,
   input  wire  [2:0]            req_expected_state,
   input  wire  [2:0]            req_next_state,
   output logic                  rsp_strobe,
   output logic                  rsp_event_valid,
   output logic [15:0]           rsp_event_service_id,
   output logic                  rsp_event_ok,
   output logic                  rsp_answer,
   output logic                  rsp_error,
   output logic [2:0]            rsp_fsm_now,
   output logic                  rsp_link_usable,
   output logic                  rsp_last
);
   import ast_pkg::*;

   localparam int CW = $clog2(MAX_SERVICES + 1);
   localparam int AW = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;

   logic [15:0]   mem [MAX_SERVICES];

   logic [2:0]    func_ff;
   logic [15:0]   id_ff;
   logic          conn_ff;
   logic [2:0]    exp_ff;
   logic [2:0]    nxt_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] idx_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          link_ff;
   logic          link_in;
   logic [2:0]    fsm_ff;
   logic [2:0]    fsm_in;
   logic          found_ff;
   logic [AW-1:0] slot_ff;
   logic [15:0]   rd_data_ff;
   logic [CW-1:0] count_m1;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;

   logic          ev;
   logic          ok;
   logic          ans;
   logic          err;
   logic          ins;

   logic          strobe_ff;
   logic          ev_ff;
   logic [15:0]   ev_id_ff;
   logic          ok_ff;
   logic          ans_ff;
   logic          err_ff;
   logic [2:0]    fsm_now_ff;
   logic          usable_ff;
   logic          last_ff;

   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      sts.scan_func  = func_ff inside {FUNC_SERVICE, FUNC_QUERY};
      sts.svc_remove = (func_ff == FUNC_SERVICE) && !conn_ff;
      sts.link_drop  = (func_ff == FUNC_LINK) && (conn_ff != link_ff) && link_ff
                       && (count_ff != '0);
      sts.scan_end   = (idx_ff >= count_ff);
      sts.hit        = (rd_data_ff == id_ff);
      sts.idx_zero   = (idx_ff == '0);
   end

   always_comb begin
      ev       = 1'b0;
      ok       = 1'b0;
      ans      = 1'b0;
      err      = 1'b0;
      ins      = 1'b0;
      fsm_in   = fsm_ff;
      link_in  = link_ff;
      count_in = count_ff;
      case (func_ff)
         FUNC_SERVICE: begin
            if (conn_ff) begin
               if (!found_ff) begin
                  if (count_ff == CW'(MAX_SERVICES)) begin
                     err = 1'b1;
                  end else begin
                     ins      = 1'b1;
                     count_in = count_ff + CW'(1);
                     ev       = 1'b1;
                     ok       = 1'b1;
                  end
               end
            end else if (found_ff) begin
               count_in = count_m1;
               ev       = 1'b1;
            end
         end
         FUNC_LINK: begin
            link_in = conn_ff;
         end
         FUNC_QUERY: begin
            ans = link_ff && (fsm_ff != RD_UNSUB) && found_ff;
         end
         FUNC_CAS: begin
            if (nxt_ff > RD_COMPLETE) begin
               err = 1'b1;
            end else if (fsm_ff == exp_ff) begin
               err    = !ast_legal(exp_ff, nxt_ff);
               fsm_in = nxt_ff;
               ans    = 1'b1;
            end
         end
         FUNC_SET: begin
            if (nxt_ff > RD_COMPLETE) begin
               err = 1'b1;
            end else begin
               err    = !ast_legal(fsm_ff, nxt_ff);
               fsm_in = nxt_ff;
            end
         end
         FUNC_RESET: begin
            fsm_in = RD_READY;
         end
         default: begin
            fsm_in = fsm_ff;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) idx_in = '0;
      else if (cmd.idx_last) idx_in = count_m1;
      else if (cmd.idx_inc) idx_in = idx_ff + CW'(1);
      else if (cmd.idx_dec) idx_in = idx_ff - CW'(1);
   end

   assign rd_addr = cmd.rd_last ? count_m1[AW-1:0] : idx_ff[AW-1:0];
   assign wr_en   = cmd.move_wr || (cmd.exec && ins);
   assign wr_addr = cmd.move_wr ? slot_ff : count_ff[AW-1:0];
   assign wr_data = cmd.move_wr ? rd_data_ff : id_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en || cmd.rd_last) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         id_ff   <= req_service_id;
         conn_ff <= req_connected;
         exp_ff  <= req_expected_state;
         nxt_ff  <= req_next_state;
      end
      if (cmd.hit_set) slot_ff <= idx_ff[AW-1:0];
      idx_ff <= idx_in;
      if (cmd.exec) begin
         ev_ff      <= ev;
         ev_id_ff   <= ev ? id_ff : 16'd0;
         ok_ff      <= ev && ok;
         ans_ff     <= ans;
         err_ff     <= err;
         fsm_now_ff <= fsm_in;
         usable_ff  <= link_in && (fsm_in != RD_UNSUB);
         last_ff    <= 1'b1;
      end else if (cmd.drain_emit) begin
         ev_ff      <= 1'b1;
         ev_id_ff   <= rd_data_ff;
         ok_ff      <= 1'b0;
         ans_ff     <= 1'b0;
         err_ff     <= 1'b0;
         fsm_now_ff <= fsm_ff;
         usable_ff  <= conn_ff && (fsm_ff != RD_UNSUB);
         last_ff    <= sts.idx_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         link_ff   <= 1'b0;
         fsm_ff    <= RD_UNSUB;
         found_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.exec || cmd.drain_emit;
         if (cmd.load) found_ff <= 1'b0;
         else if (cmd.hit_set) found_ff <= 1'b1;
         if (cmd.exec) begin
            count_ff <= count_in;
            link_ff  <= link_in;
            fsm_ff   <= fsm_in;
         end else if (cmd.drain_emit && sts.idx_zero) begin
            count_ff <= '0;
            link_ff  <= conn_ff;
         end
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_event_valid      = ev_ff;
   assign rsp_event_service_id = ev_id_ff;
   assign rsp_event_ok         = ok_ff;
   assign rsp_answer           = ans_ff;
   assign rsp_error            = err_ff;
   assign rsp_fsm_now          = fsm_now_ff;
   assign rsp_link_usable      = usable_ff;
   assign rsp_last             = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SERVICES))
      else $error("Service count exceeds the table depth.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.drain_emit && sts.idx_zero) |=> (count_ff == '0 && !link_ff))
      else $error("Link drop did not empty the set.");

   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !ev_ff) |-> last_ff)
      else $error("Result without an event is not the final one.");

   assert property (@(posedge clock) disable iff (reset)
      fsm_ff <= RD_COMPLETE)
      else $error("Read state holds an undefined code.");

endmodule

`default_nettype wire
